// ===== rtl/mzvps_pkg.sv =====
// ----------------------------------------------------------------------------
// Vibration pattern sequencer package
// Types, codes and the fixed step table shared by the sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mzvps_pkg;

  localparam int TIME_W   = 16;
  localparam int REP_W    = 3;
  localparam int PAUSE_W  = 5;
  localparam int PERIOD_W = 10;
  localparam int TABLE_LEN = 7;

  localparam logic [PAUSE_W-1:0]  PAUSE_MAX   = 5'h1F;
  localparam logic [PERIOD_W-1:0] TICK_RESET  = 10'd100;

  localparam logic [1:0] MODE_TICK      = 2'd0;
  localparam logic [1:0] MODE_PAUSE_REQ = 2'd1;
  localparam logic [1:0] MODE_PAUSE_REL = 2'd2;
  localparam logic [1:0] MODE_ENABLE    = 2'd3;

  typedef struct packed {
    logic tick;
    logic pause_req;
    logic pause_rel;
    logic enable_write;
    logic enable_value;
  } zone_cmd_t;

  typedef struct packed {
    logic [TIME_W-1:0] on_ms;
    logic [TIME_W-1:0] off_end;
    logic [REP_W-1:0]  repeats;
  } step_entry_t;

  // Steps past the end of the table reuse the first entry.
  function automatic step_entry_t step_entry(input logic [3:0] idx);
    step_entry_t e;
    unique case (idx)
      4'd0:    e = '{on_ms: 16'd0,    off_end: 16'd500,   repeats: 3'd1};
      4'd1:    e = '{on_ms: 16'd6000, off_end: 16'd8000,  repeats: 3'd4};
      4'd2:    e = '{on_ms: 16'd5000, off_end: 16'd6000,  repeats: 3'd3};
      4'd3:    e = '{on_ms: 16'd7000, off_end: 16'd10000, repeats: 3'd2};
      4'd4:    e = '{on_ms: 16'd5000, off_end: 16'd6000,  repeats: 3'd3};
      4'd5:    e = '{on_ms: 16'd6000, off_end: 16'd8000,  repeats: 3'd4};
      default: e = '{on_ms: 16'd0,    off_end: 16'd500,   repeats: 3'd1};
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mzvps_zone.sv =====
// ----------------------------------------------------------------------------
// Vibration zone
// State and per-beat update of one zone: pause count, enable, step timing.
// ----------------------------------------------------------------------------
`default_nettype none

module mzvps_zone
  import mzvps_pkg::*;
#(
  parameter int STEP_COUNT = 7,
  parameter int STEP_W = 3
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                update,
  input  wire zone_cmd_t           cmd,
  input  wire logic [PERIOD_W-1:0] tick_period,
  output logic                     running,
  output logic                     paused,
  output logic [STEP_W-1:0]        step
);

  logic [STEP_W-1:0]  step_index;
  logic [TIME_W-1:0]  step_time;
  logic [REP_W-1:0]   repeat_count;
  logic [PAUSE_W-1:0] pause_count;
  logic               zone_enabled;
  logic               zone_running;

  logic [STEP_W-1:0]  step_index_next;
  logic [TIME_W-1:0]  step_time_next;
  logic [REP_W-1:0]   repeat_count_next;
  logic [PAUSE_W-1:0] pause_count_next;
  logic               zone_enabled_next;
  logic               zone_running_next;

  step_entry_t       entry;
  logic [TIME_W-1:0] time_sum;
  logic [REP_W-1:0]  rep_inc;

  assign entry    = step_entry(4'(step_index));
  assign time_sum = step_time + TIME_W'(tick_period);
  assign rep_inc  = repeat_count + REP_W'(1);

  always_comb begin
    step_index_next   = step_index;
    step_time_next    = step_time;
    repeat_count_next = repeat_count;
    pause_count_next  = pause_count;
    zone_enabled_next = zone_enabled;
    zone_running_next = zone_running;
    if (cmd.tick) begin
      if (pause_count != '0) begin
        zone_running_next = 1'b0;
      end else if (!zone_enabled) begin
        step_index_next   = '0;
        step_time_next    = '0;
        repeat_count_next = '0;
        zone_running_next = 1'b0;
      end else if (time_sum < entry.on_ms) begin
        step_time_next    = time_sum;
        zone_running_next = 1'b1;
      end else if (time_sum < entry.off_end) begin
        step_time_next    = time_sum;
        zone_running_next = 1'b0;
      end else begin
        step_time_next = '0;
        if (rep_inc >= entry.repeats) begin
          repeat_count_next = '0;
          if (step_index == STEP_W'(STEP_COUNT - 1)) begin
            step_index_next = '0;
          end else begin
            step_index_next = step_index + STEP_W'(1);
          end
        end else begin
          repeat_count_next = rep_inc;
        end
      end
    end else if (cmd.pause_req) begin
      if (pause_count != PAUSE_MAX) begin
        pause_count_next = pause_count + PAUSE_W'(1);
      end
    end else if (cmd.pause_rel) begin
      if (pause_count != '0) begin
        pause_count_next = pause_count - PAUSE_W'(1);
      end
    end else if (cmd.enable_write) begin
      zone_enabled_next = cmd.enable_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_index   <= '0;
      step_time    <= '0;
      repeat_count <= '0;
      pause_count  <= '0;
      zone_enabled <= 1'b0;
      zone_running <= 1'b0;
    end else if (update) begin
      step_index   <= step_index_next;
      step_time    <= step_time_next;
      repeat_count <= repeat_count_next;
      pause_count  <= pause_count_next;
      zone_enabled <= zone_enabled_next;
      zone_running <= zone_running_next;
    end
  end

  assign running = zone_running;
  assign paused  = (pause_count != '0);
  assign step    = step_index;

endmodule

`default_nettype wire

// ===== rtl/multi_zone_vibration_pattern_sequencer.sv =====
// ----------------------------------------------------------------------------
// Multi-zone vibration pattern sequencer
// Drives several vibration zones through a fixed on/off step pattern.
// ----------------------------------------------------------------------------
// The block takes one beat per clock cycle while in_stall is low and returns
// one result beat per input beat: the beat is held in the input register and
// then applied in the zone state update, whose registers form the result.
// Each tick beat advances every enabled, unpaused zone by the tick period with
// one time add and three compares per zone. The user must write the tick
// period through cfg_we and cfg_wdata only while the block is idle; the block does not enforce it.
`default_nettype none

module multi_zone_vibration_pattern_sequencer
  import mzvps_pkg::*;
#(
  parameter int ZONE_COUNT = 4,
  parameter int STEP_COUNT = 7
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [PERIOD_W-1:0] cfg_wdata,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          mode,
  input  wire logic [1:0]          zone,
  input  wire logic [7:0]          enable_value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [3:0]               run_mask,
  output logic [3:0]               paused_mask,
  output logic [2:0]               feet_step,
  output logic [2:0]               calves_step,
  output logic [2:0]               seat_step,
  output logic [2:0]               lumbar_step
);

  localparam int STEP_W = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;

  logic [PERIOD_W-1:0] tick_period;
  logic                s1_valid;
  logic [1:0]          s1_mode;
  logic [1:0]          s1_zone;
  logic [7:0]          s1_enable_value;
  logic                advance;
  logic                update;

  logic              zone_running [ZONE_COUNT];
  logic              zone_paused [ZONE_COUNT];
  logic [STEP_W-1:0] zone_step [ZONE_COUNT];
  logic [2:0]        step_out [4];

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign update   = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period <= TICK_RESET;
    end else if (cfg_we) begin
      tick_period <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_mode         <= mode;
      s1_zone         <= zone;
      s1_enable_value <= enable_value;
    end
  end

  for (genvar z = 0; z < ZONE_COUNT; z++) begin : g_zone
    zone_cmd_t cmd;
    logic      hit;

    assign hit = ({1'b0, s1_zone} == 3'(z));
    assign cmd.tick         = (s1_mode == MODE_TICK);
    assign cmd.pause_req    = hit && (s1_mode == MODE_PAUSE_REQ);
    assign cmd.pause_rel    = hit && (s1_mode == MODE_PAUSE_REL);
    assign cmd.enable_write = hit && (s1_mode == MODE_ENABLE);
    assign cmd.enable_value = (s1_enable_value == 8'd1);

    mzvps_zone #(
      .STEP_COUNT(STEP_COUNT),
      .STEP_W(STEP_W)
    ) u_zone (
      .clk(clk),
      .rst(rst),
      .update(update),
      .cmd(cmd),
      .tick_period(tick_period),
      .running(zone_running[z]),
      .paused(zone_paused[z]),
      .step(zone_step[z])
    );
  end

  for (genvar z = 0; z < 4; z++) begin : g_out
    if (z < ZONE_COUNT) begin : g_used
      assign run_mask[z]    = zone_running[z];
      assign paused_mask[z] = zone_paused[z];
      assign step_out[z]    = 3'(zone_step[z]);
    end else begin : g_unused
      assign run_mask[z]    = 1'b0;
      assign paused_mask[z] = 1'b0;
      assign step_out[z]    = 3'd0;
    end
  end

  assign feet_step   = step_out[0];
  assign calves_step = step_out[1];
  assign seat_step   = step_out[2];
  assign lumbar_step = step_out[3];

endmodule

`default_nettype wire
